[src/knn_pkg.sv]
// Shared types and constants for the k-nearest-neighbour list update core.
// Depends on nothing; used by the core and by its checker.
package knn_pkg;

	localparam int LIST_LEN = 40;
	localparam int NODES    = 1024;

	localparam int SLOT_W = $clog2(LIST_LEN);
	localparam int CNT_W  = $clog2(LIST_LEN + 1);
	localparam int NODE_W = $clog2(NODES);

	localparam logic [1:0] OP_OFFER = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [9:0]  node_id;
		logic [5:0]  slot;
		logic [9:0]  neighbour_id;
		logic [31:0] distance;
		logic        fresh_in;
	} item_t;

	typedef struct packed {
		logic        accepted;
		logic [5:0]  position;
		logic [9:0]  read_neighbour;
		logic [31:0] read_distance;
		logic        read_fresh;
	} result_t;

	typedef struct packed {
		logic [9:0]  neighbour;
		logic [31:0] distance;
		logic        fresh;
	} entry_t;

	typedef entry_t [LIST_LEN-1:0] row_t;

endpackage

[src/knn_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module knn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/knn_list_sorted_insert_core.sv]
// Neighbour list update core: one row-wide list memory and its update sequencer.
// Depends on knn_pkg and knn_ram.
//
// Holds one sorted neighbour list of LIST_LEN entries per node, a whole list
// in one row of a single RAM (NODES rows). Each transfer passes through the
// idle, look and commit states: the row is read in the cycle of the input
// transfer, the distance and neighbour compares across all entries are
// registered in the next, and in the commit state the insertion point is
// found, the row shifted and written back and the result loaded into the
// output register. One item is in flight at a time, so an offer always sees
// the row left by the one before it and no forwarding is needed. A new item
// is taken while a finished result still waits in the output register; the
// core only holds in its commit state if that register is still full. No
// new item is taken until the last is written back, a read-compare-write loop on
// the row RAM. Memory contents are undefined after reset; every list must
// be written entry by entry before it is offered to or read.
module knn_list_sorted_insert_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  knn_pkg::item_t  item,
	output logic            result_valid,
	input  logic            result_ready,
	output knn_pkg::result_t result
);

	localparam int LEN    = knn_pkg::LIST_LEN;
	localparam int SLOT_W = knn_pkg::SLOT_W;
	localparam int CNT_W  = knn_pkg::CNT_W;
	localparam int ADDR_W = knn_pkg::NODE_W;
	localparam int ROW_W  = $bits(knn_pkg::row_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_COMMIT
	} state_t;

	state_t           state_q;
	knn_pkg::item_t   item_q;
	knn_pkg::result_t result_q;
	logic             result_valid_q;

	// per-entry compare flags, registered in the cycle after the row read
	logic [LEN-1:0] gt_s1;
	logic [LEN-1:0] lt_s1;
	logic [LEN-1:0] nbeq_s1;

	logic [ROW_W-1:0] rdata;
	knn_pkg::row_t    row_cur;
	knn_pkg::row_t    row_new;
	knn_pkg::entry_t  new_e;
	knn_pkg::result_t result_d;

	logic              take;
	logic              commit;
	logic              ram_we;
	logic              node_ok;
	logic              slot_ok;
	logic [SLOT_W-1:0] slot_idx;
	logic [CNT_W-1:0]  ins;
	logic [CNT_W-1:0]  scan_lo;
	logic [SLOT_W-1:0] pos;
	logic              dup;
	logic              too_far;
	logic              offer_ok;
	logic [LEN-1:0]    gt_d;
	logic [LEN-1:0]    lt_d;
	logic [LEN-1:0]    nbeq_d;

	assign item_ready   = (state_q == ST_IDLE);
	assign take         = item_valid && item_ready;
	assign commit       = (state_q == ST_COMMIT) && (!result_valid_q || result_ready);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign row_cur  = knn_pkg::row_t'(rdata);
	assign node_ok  = 32'(item_q.node_id) < knn_pkg::NODES;
	assign slot_ok  = 32'(item_q.slot) < LEN;
	assign slot_idx = item_q.slot[SLOT_W-1:0];

	// row RAM: read on the input transfer, written back on commit
	knn_ram #(
		.WIDTH(ROW_W),
		.DEPTH(knn_pkg::NODES)
	) u_row_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ADDR_W'(item_q.node_id)),
		.wdata(ROW_W'(row_new)),
		.re   (take),
		.raddr(ADDR_W'(item.node_id)),
		.rdata(rdata)
	);

	// compares of the offer against every entry of the row
	always_comb begin
		for (int i = 0; i < LEN; i++) begin
			gt_d[i]   = row_cur[i].distance > item_q.distance;
			lt_d[i]   = row_cur[i].distance < item_q.distance;
			nbeq_d[i] = row_cur[i].neighbour == item_q.neighbour_id;
		end
	end

	// insertion point, duplicate scan, shifted row and result
	always_comb begin
		// insertion point: just after the last entry that is not farther
		ins = '0;
		for (int i = 0; i < LEN; i++) begin
			if (!gt_s1[i]) begin
				ins = CNT_W'(i + 1);
			end
		end
		// duplicate scan stops at the last nearer entry below the insertion point
		scan_lo = '0;
		for (int i = 0; i < LEN; i++) begin
			if (lt_s1[i] && (CNT_W'(i) < ins)) begin
				scan_lo = CNT_W'(i + 1);
			end
		end
		dup = 1'b0;
		for (int i = 0; i < LEN; i++) begin
			if (nbeq_s1[i] && (CNT_W'(i) >= scan_lo) && (CNT_W'(i) < ins)) begin
				dup = 1'b1;
			end
		end
		too_far = lt_s1[LEN-1];
		// a tie with the last entry replaces it
		pos = (ins > CNT_W'(LEN - 1)) ? SLOT_W'(LEN - 1) : SLOT_W'(ins);

		offer_ok = node_ok && (item_q.operation == knn_pkg::OP_OFFER) && !too_far && !dup;

		new_e.neighbour = item_q.neighbour_id;
		new_e.distance  = item_q.distance;
		new_e.fresh     = 1'b1;

		row_new = row_cur;
		ram_we  = 1'b0;
		case (item_q.operation)
			knn_pkg::OP_OFFER: begin
				if (pos == '0) begin
					row_new[0] = new_e;
				end
				for (int k = 1; k < LEN; k++) begin
					if (SLOT_W'(k) > pos) begin
						row_new[k] = row_cur[k-1];
					end else if (SLOT_W'(k) == pos) begin
						row_new[k] = new_e;
					end
				end
				ram_we = commit && offer_ok;
			end
			knn_pkg::OP_WRITE: begin
				if (slot_ok) begin
					row_new[slot_idx].neighbour = item_q.neighbour_id;
					row_new[slot_idx].distance  = item_q.distance;
					row_new[slot_idx].fresh     = item_q.fresh_in;
				end
				ram_we = commit && node_ok && slot_ok;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase

		result_d = '0;
		if (offer_ok) begin
			result_d.accepted = 1'b1;
			result_d.position = 6'(pos);
		end
		if (node_ok && slot_ok && (item_q.operation == knn_pkg::OP_READ)) begin
			result_d.read_neighbour = row_cur[slot_idx].neighbour;
			result_d.read_distance  = row_cur[slot_idx].distance;
			result_d.read_fresh     = row_cur[slot_idx].fresh;
		end
	end

	// sequencer, item holding register, compare flags and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			item_q         <= '0;
			gt_s1          <= '0;
			lt_s1          <= '0;
			nbeq_s1        <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// output register: loaded on commit, emptied on the output transfer
			if (commit) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						item_q  <= item;
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					gt_s1   <= gt_d;
					lt_s1   <= lt_d;
					nbeq_s1 <= nbeq_d;
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (commit) begin
						result_q <= result_d;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[src/knn_checker.sv]
// Port-level checks for the neighbour list update core, bound to its top level.
// Depends on knn_pkg and knn_list_sorted_insert_core.
module knn_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input logic             result_valid,
	input logic             result_ready,
	input knn_pkg::result_t result
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// one item in flight: no transfer right after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("input taken while an item is in flight");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.accepted |-> result.position == 6'd0)
		else $error("position set on a result that was not accepted");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.accepted |-> 32'(result.position) < knn_pkg::LIST_LEN)
		else $error("insert position beyond list length");

	a_offer_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.accepted |->
			result.read_neighbour == 10'd0 && result.read_distance == 32'd0 &&
			!result.read_fresh)
		else $error("read fields set on an accepted offer");

endmodule

bind knn_list_sorted_insert_core knn_checker u_knn_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);

[tb/knn_list_sorted_insert_core_tb.sv]
// Self-checking bench for knn_list_sorted_insert_core: offers, writes and reads on neighbour lists.
// Depends on knn_pkg and the core. It keeps its own copy of every list and checks each reply in order.
`timescale 1ns / 1ps

module knn_list_sorted_insert_core_tb;

	localparam int LIST_LEN = knn_pkg::LIST_LEN;
	localparam int NODES    = knn_pkg::NODES;

	// operation code that the core must answer with an all-zero reply
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam int POOL        = 8;      // nodes kept as full lists for offers
	localparam int N_RANDOM    = 1550;
	localparam int REFILL_GAP  = 250;    // random items between list reloads
	localparam int IDLE_PCT    = 19;
	localparam int QUIET_LO    = 1500;   // cycle window with no idling on either side
	localparam int QUIET_HI    = 3000;
	localparam int TAIL_CYCLES = 12;     // core holds one item at a time
	localparam int MAX_SHOWN   = 40;
	localparam longint LIMIT_NS = 400_000;

	// one pending transfer; hold makes the sender wait until every reply is in
	typedef struct packed {
		logic           hold;
		knn_pkg::item_t body;
	} cmd_t;

	typedef struct packed {
		logic [9:0] node;
		logic [5:0] slot;
	} loc_t;

	logic             clk;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	logic             item_ready;
	knn_pkg::item_t   item         = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	knn_pkg::result_t result;

	knn_list_sorted_insert_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	int unsigned cyc = 0;
	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// bench copy of every list, updated as each input transfer is accepted
	knn_pkg::entry_t nn_lists [NODES][LIST_LEN];

	cmd_t             cmd_q [$];
	knn_pkg::result_t due_replies [$];

	int n_sent     = 0;   // driver side, blocking
	int n_recv     = 0;   // monitor side, nonblocking so the driver sees a stable value
	int errors     = 0;
	int n_offers   = 0;
	int n_inserted = 0;
	int n_reads    = 0;
	int n_refills  = 0;

	// generator view of each pool list as it was loaded
	logic [9:0]  pool_node [POOL];
	logic [31:0] band_d [POOL][LIST_LEN];
	loc_t        stray_q [$];

	function automatic bit quiet();
		return cyc >= QUIET_LO && cyc < QUIET_HI;
	endfunction

	function automatic bit take_gap();
		return !quiet() && $urandom_range(0, 99) < IDLE_PCT;
	endfunction

	// Sorted insertion into one list, with the same scans on unsorted contents.
	function automatic knn_pkg::result_t apply_to_lists(input knn_pkg::item_t it);
		knn_pkg::result_t r;
		int      n;
		int      ins;
		int      scan;
		int      k;
		bit      dup;
		r = '0;
		n = it.node_id;
		if (n >= NODES)
			return r;
		case (it.operation)
			knn_pkg::OP_OFFER: begin
				if (nn_lists[n][LIST_LEN-1].distance >= it.distance) begin
					// insertion point: after every entry not farther than the offer
					ins = LIST_LEN;
					while (ins > 0 && nn_lists[n][ins-1].distance > it.distance)
						ins--;
					// duplicate check over the tied run just below it
					dup  = 1'b0;
					scan = ins;
					while (scan > 0 && !dup && nn_lists[n][scan-1].distance >= it.distance) begin
						if (nn_lists[n][scan-1].neighbour == it.neighbour_id)
							dup = 1'b1;
						scan--;
					end
					if (!dup) begin
						// a tie with the last entry replaces it
						if (ins > LIST_LEN - 1)
							ins = LIST_LEN - 1;
						for (k = LIST_LEN - 1; k > ins; k--)
							nn_lists[n][k] = nn_lists[n][k-1];
						nn_lists[n][ins] = '{neighbour: it.neighbour_id,
							distance: it.distance, fresh: 1'b1};
						r.accepted = 1'b1;
						r.position = ins[5:0];
					end
				end
			end
			knn_pkg::OP_WRITE: begin
				if (it.slot < LIST_LEN)
					nn_lists[n][it.slot] = '{neighbour: it.neighbour_id,
						distance: it.distance, fresh: it.fresh_in};
			end
			knn_pkg::OP_READ: begin
				if (it.slot < LIST_LEN) begin
					r.read_neighbour = nn_lists[n][it.slot].neighbour;
					r.read_distance  = nn_lists[n][it.slot].distance;
					r.read_fresh     = nn_lists[n][it.slot].fresh;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Driver: presents the head of cmd_q, predicting each transfer as it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
		end else begin
			if (item_valid && item_ready) begin
				due_replies.insert(due_replies.size(), apply_to_lists(item));
				n_sent++;
				if (item.operation == knn_pkg::OP_OFFER) begin
					n_offers++;
					if (due_replies[$].accepted)
						n_inserted++;
				end
				if (item.operation == knn_pkg::OP_READ)
					n_reads++;
			end
			if (!item_valid || item_ready) begin
				// slot free after this edge: next item, a gap, or a wait for drain
				if (cmd_q.size() != 0 && !take_gap() && !(cmd_q[0].hold && n_recv != n_sent)) begin
					item       <= cmd_q[0].body;
					item_valid <= 1'b1;
					void'(cmd_q.pop_front());
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			if (errors < MAX_SHOWN)
				$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
			errors++;
		end
	endtask

	// Monitor: random back-pressure, each reply checked against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		knn_pkg::result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				n_recv <= n_recv + 1;
				if (due_replies.size() == 0) begin
					if (errors < MAX_SHOWN)
						$display("%0t ns: reply with nothing outstanding, expected none, got %h",
							$time, result);
					errors++;
				end else begin
					want = due_replies.pop_front();
					check_field("accepted", want.accepted, result.accepted);
					check_field("position", want.position, result.position);
					check_field("read_neighbour", want.read_neighbour, result.read_neighbour);
					check_field("read_distance", want.read_distance, result.read_distance);
					check_field("read_fresh", want.read_fresh, result.read_fresh);
				end
			end
			result_ready <= !take_gap();
		end
	end

	task automatic push_cmd(input logic [1:0] op, input int node, input int slot, input int nb,
			input logic [31:0] dist_key, input bit fr, input bit hold);
		cmd_t c;
		c.hold              = hold;
		c.body.operation    = op;
		c.body.node_id      = node[9:0];
		c.body.slot         = slot[5:0];
		c.body.neighbour_id = nb[9:0];
		c.body.distance     = dist_key;
		c.body.fresh_in     = fr;
		cmd_q.insert(cmd_q.size(), c);
	endtask

	// small neighbour range most of the time so that duplicates are common
	function automatic int pick_nb();
		return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 47);
	endfunction

	// Loads a whole pool list, sorted with frequent ties, in shuffled slot order.
	task automatic fill_list(input int p, input logic [31:0] lo, input bit hold);
		int          perm [LIST_LEN];
		int          i;
		int          j;
		int          t;
		logic [31:0] d;
		d = lo;
		for (i = 0; i < LIST_LEN; i++) begin
			if (i > 0 && $urandom_range(0, 3) != 0)
				d = d + $urandom_range(1, 60);
			band_d[p][i] = d;
			perm[i] = i;
		end
		for (i = LIST_LEN - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		for (i = 0; i < LIST_LEN; i++)
			push_cmd(knn_pkg::OP_WRITE, pool_node[p], perm[i], pick_nb(), band_d[p][perm[i]],
				$urandom_range(0, 1), hold && i == 0);
	endtask

	function automatic logic [31:0] pick_base();
		case ($urandom_range(0, 3))
			0:       return 32'h0;
			1:       return 32'hFFFF_F000;
			default: return $urandom_range(0, 32'hFFFF_0000);
		endcase
	endfunction

	initial begin
		int          i;
		int          p;
		int          r;
		int          s;
		int          n_rand;
		int          next_refill;
		logic [31:0] d;
		loc_t        loc;

		// Directed: node 1023 with a tied run holding neighbour 1023 and a near-top last entry
		for (i = 0; i < LIST_LEN; i++) begin
			d = (i >= 5 && i <= 7) ? 32'd500 : i * 100;
			if (i == LIST_LEN - 1)
				d = 32'hFFFF_FFFE;
			push_cmd(knn_pkg::OP_WRITE, 1023, i, (i == 6) ? 1023 : i + 1, d, i[0], 1'b0);
		end
		push_cmd(knn_pkg::OP_READ,  1023, 0, 0, 0, 0, 1'b0);
		push_cmd(knn_pkg::OP_OFFER, 1023, 0, 5, 32'hFFFF_FFFF, 1, 1'b0);   // beyond last entry
		push_cmd(knn_pkg::OP_OFFER, 1023, 0, 1023, 32'd500, 0, 1'b0);      // already in the tied run
		push_cmd(knn_pkg::OP_OFFER, 1023, 63, 900, 32'd500, 0, 1'b0);      // after the tied run
		push_cmd(knn_pkg::OP_OFFER, 1023, 0, 0, 32'd0, 0, 1'b0);
		push_cmd(knn_pkg::OP_OFFER, 1023, 0, 77, 32'hFFFF_FFFE, 0, 1'b0);  // beyond the last entry now, rejected
		push_cmd(knn_pkg::OP_OFFER, 1023, 0, 78, 32'd50, 1, 1'b0);
		push_cmd(knn_pkg::OP_OFFER, 1023, 0, 1, 32'd0, 0, 1'b0);           // duplicate at the head
		push_cmd(knn_pkg::OP_READ,  1023, 39, 0, 0, 0, 1'b0);
		push_cmd(knn_pkg::OP_READ,  1023, 1, 0, 0, 0, 1'b0);
		push_cmd(knn_pkg::OP_READ,  1023, 8, 0, 0, 0, 1'b0);
		push_cmd(knn_pkg::OP_READ,  1023, 40, 0, 0, 0, 1'b0);
		push_cmd(knn_pkg::OP_READ,  1023, 63, 1023, 32'hFFFF_FFFF, 1, 1'b0);
		push_cmd(knn_pkg::OP_WRITE, 1023, 40, 1023, 32'h0, 1, 1'b0);       // slot beyond the list
		push_cmd(knn_pkg::OP_WRITE, 1023, 63, 1023, 32'h0, 1, 1'b0);
		push_cmd(knn_pkg::OP_READ,  1023, 39, 0, 0, 0, 1'b0);
		push_cmd(OP_SPARE, 1023, 63, 1023, 32'hFFFF_FFFF, 1, 1'b0);
		push_cmd(OP_SPARE, 0, 0, 0, 32'h0, 0, 1'b0);
		push_cmd(knn_pkg::OP_WRITE, 0, 39, 1023, 32'hFFFF_FFFF, 1, 1'b0);
		push_cmd(knn_pkg::OP_READ,  0, 39, 0, 0, 0, 1'b0);
		push_cmd(knn_pkg::OP_WRITE, 0, 0, 0, 32'h0, 0, 1'b0);
		push_cmd(knn_pkg::OP_READ,  0, 0, 1023, 32'hFFFF_FFFF, 1, 1'b0);

		// Random: full pool lists, then offers with reads, rewrites and noise mixed in
		pool_node[0] = 10'd0;
		pool_node[1] = 10'd1023;
		for (p = 2; p < POOL; p++)
			pool_node[p] = $urandom_range(1, 1022);
		for (p = 0; p < POOL; p++)
			fill_list(p, (p == 0) ? 32'h0 : (p == 1) ? 32'hFFFF_F000 : pick_base(), p == 0);
		n_rand      = POOL * LIST_LEN;
		next_refill = n_rand + REFILL_GAP;
		while (n_rand < N_RANDOM) begin
			if (n_rand >= next_refill) begin
				// drain everything, then reload one list with a fresh sorted band
				fill_list($urandom_range(0, POOL - 1), pick_base(), 1'b1);
				n_refills++;
				n_rand     += LIST_LEN;
				next_refill = n_rand + REFILL_GAP;
			end
			p = $urandom_range(0, POOL - 1);
			r = $urandom_range(0, 99);
			if (r < 60) begin
				s = $urandom_range(0, 9);
				if (s < 5)
					d = band_d[p][0] + $urandom_range(0,
						band_d[p][LIST_LEN-1] - band_d[p][0] + 20);
				else if (s < 8)
					d = band_d[p][$urandom_range(0, LIST_LEN - 1)];
				else
					d = $urandom;
				push_cmd(knn_pkg::OP_OFFER, pool_node[p], $urandom_range(0, 63), pick_nb(), d,
					$urandom_range(0, 1), 1'b0);
				n_rand++;
			end else if (r < 75) begin
				push_cmd(knn_pkg::OP_READ, pool_node[p], $urandom_range(0, LIST_LEN - 1),
					pick_nb(), $urandom, $urandom_range(0, 1), 1'b0);
				n_rand++;
			end else if (r < 80) begin
				// overwrite inside a full list; may leave it unsorted
				d = $urandom_range(0, 1) ? band_d[p][$urandom_range(0, LIST_LEN - 1)] : $urandom;
				push_cmd(knn_pkg::OP_WRITE, pool_node[p], $urandom_range(0, LIST_LEN - 1),
					pick_nb(), d, $urandom_range(0, 1), 1'b0);
				n_rand++;
			end else if (r < 87) begin
				loc.node = $urandom_range(0, 1023);
				loc.slot = $urandom_range(0, LIST_LEN - 1);
				push_cmd(knn_pkg::OP_WRITE, loc.node, loc.slot, $urandom_range(0, 1023), $urandom,
					$urandom_range(0, 1), 1'b0);
				if (stray_q.size() < 64)
					stray_q.insert(stray_q.size(), loc);
				n_rand++;
			end else if (r < 90) begin
				if (stray_q.size() != 0) begin
					loc = stray_q[$urandom_range(0, stray_q.size() - 1)];
					push_cmd(knn_pkg::OP_READ, loc.node, loc.slot, 0, 0, 0, 1'b0);
				end else begin
					push_cmd(knn_pkg::OP_READ, pool_node[p], $urandom_range(0, LIST_LEN - 1),
						0, 0, 0, 1'b0);
				end
				n_rand++;
			end else if (r < 96) begin
				push_cmd($urandom_range(0, 1) ? knn_pkg::OP_WRITE : knn_pkg::OP_READ,
					$urandom_range(0, 1023), $urandom_range(LIST_LEN, 63),
					$urandom_range(0, 1023), $urandom, $urandom_range(0, 1), 1'b0);
				n_rand++;
			end else begin
				push_cmd(OP_SPARE, $urandom_range(0, 1023), $urandom_range(0, 63),
					$urandom_range(0, 1023), $urandom, $urandom_range(0, 1), 1'b0);
				n_rand++;
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_q.size() != 0 || item_valid || n_recv != n_sent)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (due_replies.size() != 0) begin
			$display("%0t ns: replies missing, expected %0d more, got none", $time,
				due_replies.size());
			errors += due_replies.size();
		end
		$display("Covered %0d transfers: %0d offers (%0d inserted), %0d reads, %0d list reloads.",
			n_sent, n_offers, n_inserted, n_reads, n_refills);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run
	initial begin
		#(LIMIT_NS);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
